>>> design/tpg_pkg.sv
// Shared constants, field widths and command codes of the turtle plotter.
package tpg_pkg;

  localparam int unsigned GridSizeDef = 32;

  localparam int unsigned ModeW  = 3;
  localparam int unsigned DistW  = 6;
  localparam int unsigned CoordW = 5;
  localparam int unsigned HeadW  = 2;

  typedef enum logic [ModeW-1:0] {
    ModePenUp     = 3'd0,
    ModePenDown   = 3'd1,
    ModeTurnRight = 3'd2,
    ModeTurnLeft  = 3'd3,
    ModeAdvance   = 3'd4,
    ModeReadCell  = 3'd5
  } mode_e;

endpackage

>>> design/tpg_bitmap.sv
// Row-organised bitmap memory with per-row valid bits and a registered read port.
module tpg_bitmap import tpg_pkg::*; #(
  parameter int unsigned GRID_SIZE = GridSizeDef,
  parameter int unsigned AddrW     = $clog2(GridSizeDef)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  logic [AddrW-1:0]     rd_row_i,
  output logic [GRID_SIZE-1:0] rd_data_o,
  input  logic                 wr_en_i,
  input  logic [AddrW-1:0]     wr_row_i,
  input  logic [GRID_SIZE-1:0] wr_data_i
);

  logic [GRID_SIZE-1:0] mem_q [GRID_SIZE];
  logic [GRID_SIZE-1:0] row_vld_q;
  logic [GRID_SIZE-1:0] rd_data_q;
  logic                 rd_vld_q;

  // valid bits: cleared at reset, set on first write of a row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_vld_q[wr_row_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= row_vld_q[rd_row_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_row_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_row_i];
    end
  end

  // drop stale contents of rows not written since reset
  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

>>> design/turtle_pen_plotter_grid.sv
// Top level of the turtle pen plotter: command sequencer around the bitmap memory.
//
// Usage: one request on the input channel (mode_i, distance_i, query_row_i,
// query_col_i) carries one command; each request yields exactly one result on
// the output channel (cell_marked_o, row_now_o, col_now_o, heading_now_o,
// pen_is_down_o, clipped_o). Both channels use valid/ready.
// Sequencing per command: pen up/down, turns, advance with pen up or zero
// distance, and unused modes go straight to the result; read cell does one
// bitmap read, and a query off the grid reads blank without one; advance with
// pen down along a row does one read-modify-write of one row; along a column
// it marks n cells, n <= GRID_SIZE, one row at a time.
// The bitmap memory has one read and one write port; a column advance streams
// one row per cycle, the read of the next row overlapping the write of the last.
// One command is processed at a time; in_ready_o is high while the sequencer idles.
// The result sits in an output register, so a new request is accepted while the
// last result still waits; a stalled receiver holds the next result in the
// sequencer until the output register frees.
// Reset: turtle at row 0, column 0, heading 0, pen up; every bitmap row reads
// blank through per-row valid bits, so no clearing pass is needed.
module turtle_pen_plotter_grid import tpg_pkg::*; #(
  parameter int unsigned GRID_SIZE = GridSizeDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ModeW-1:0]  mode_i,
  input  logic [DistW-1:0]  distance_i,
  input  logic [CoordW-1:0] query_row_i,
  input  logic [CoordW-1:0] query_col_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              cell_marked_o,
  output logic [CoordW-1:0] row_now_o,
  output logic [CoordW-1:0] col_now_o,
  output logic [HeadW-1:0]  heading_now_o,
  output logic              pen_is_down_o,
  output logic              clipped_o
);

  // position width, and a signed width wide enough for position +/- distance
  localparam int unsigned PW = $clog2(GRID_SIZE);
  localparam int unsigned EW = ((PW > DistW) ? PW : DistW) + 2;
  localparam logic signed [EW-1:0] LastPos = EW'(GRID_SIZE - 1);
  localparam logic [EW-1:0]        GridLim = EW'(GRID_SIZE);

  typedef enum logic [2:0] {
    StIdle,
    StMarkRd,
    StMarkWr,
    StQryRd,
    StQryCap,
    StDone
  } state_e;

  state_e              state_q;
  logic [PW-1:0]       row_pos_q, col_pos_q;
  logic [HeadW-1:0]    heading_q;
  logic                pen_q;
  // marking walk: current row, final row, column span of the mask, direction
  logic [PW-1:0]       cur_q, end_q, lo_q, hi_q, qcol_q;
  logic                dec_q;
  logic                cell_q, clip_q;
  // output register
  logic                out_valid_q;
  logic                out_cell_q, out_pen_q, out_clip_q;
  logic [CoordW-1:0]   out_row_q, out_col_q;
  logic [HeadW-1:0]    out_head_q;

  logic                in_fire, out_free;
  logic                vert, dec, adv_clip, q_in_grid, mark_last;
  logic [PW-1:0]       axis_pos, new_axis, cur_next;
  logic signed [EW-1:0] axis_ext, step_ext, sum;
  logic [EW-1:0]       qrow_ext, qcol_ext, row_ext, col_ext;
  logic [GRID_SIZE-1:0] mask, rd_data, wr_data;
  logic                rd_en, wr_en;
  logic [PW-1:0]       rd_row;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // advance target: one axis moves by distance-1, saturating at the grid edge
  always_comb begin
    vert     = ~heading_q[0];
    dec      = heading_q[1];
    axis_pos = vert ? row_pos_q : col_pos_q;
    axis_ext = EW'(axis_pos);
    step_ext = EW'(distance_i) - EW'(1);
    sum      = dec ? (axis_ext - step_ext) : (axis_ext + step_ext);
    adv_clip = 1'b0;
    if (sum < 0) begin
      new_axis = '0;
      adv_clip = 1'b1;
    end else if (sum > LastPos) begin
      new_axis = LastPos[PW-1:0];
      adv_clip = 1'b1;
    end else begin
      new_axis = sum[PW-1:0];
    end
  end

  assign qrow_ext  = EW'(query_row_i);
  assign qcol_ext  = EW'(query_col_i);
  assign q_in_grid = (qrow_ext < GridLim) && (qcol_ext < GridLim);

  // cells of the current row to mark: columns lo..hi
  always_comb begin
    for (int j = 0; j < GRID_SIZE; j++) begin
      mask[j] = (j >= int'(lo_q)) && (j <= int'(hi_q));
    end
  end

  assign wr_data   = rd_data | mask;
  assign mark_last = (cur_q == end_q);
  assign cur_next  = dec_q ? (cur_q - PW'(1)) : (cur_q + PW'(1));

  // read the next row while writing back the current one
  assign rd_en  = (state_q == StMarkRd) || (state_q == StQryRd) ||
                  ((state_q == StMarkWr) && !mark_last);
  assign rd_row = (state_q == StMarkWr) ? cur_next : cur_q;
  assign wr_en  = (state_q == StMarkWr);

  tpg_bitmap #(
    .GRID_SIZE (GRID_SIZE),
    .AddrW     (PW)
  ) u_bitmap (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_row_i  (rd_row),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_row_i  (cur_q),
    .wr_data_i (wr_data)
  );

  assign row_ext = EW'(row_pos_q);
  assign col_ext = EW'(col_pos_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      row_pos_q   <= '0;
      col_pos_q   <= '0;
      heading_q   <= '0;
      pen_q       <= 1'b0;
      cur_q       <= '0;
      end_q       <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      qcol_q      <= '0;
      dec_q       <= 1'b0;
      cell_q      <= 1'b0;
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_cell_q  <= 1'b0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_head_q  <= '0;
      out_pen_q   <= 1'b0;
      out_clip_q  <= 1'b0;
    end else begin
      // raise valid when a result moves in, drop it once the receiver takes it
      if ((state_q == StDone) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_fire) begin
            cell_q  <= 1'b0;
            clip_q  <= 1'b0;
            state_q <= StDone;
            unique case (mode_i)
              ModePenUp:     pen_q <= 1'b0;
              ModePenDown:   pen_q <= 1'b1;
              ModeTurnRight: heading_q <= heading_q + HeadW'(1);
              ModeTurnLeft:  heading_q <= heading_q - HeadW'(1);
              ModeAdvance: begin
                if (distance_i != '0) begin
                  clip_q <= adv_clip;
                  if (vert) begin
                    row_pos_q <= new_axis;
                  end else begin
                    col_pos_q <= new_axis;
                  end
                  if (pen_q) begin
                    state_q <= StMarkRd;
                    cur_q   <= row_pos_q;
                    dec_q   <= dec;
                    if (vert) begin
                      end_q <= new_axis;
                      lo_q  <= col_pos_q;
                      hi_q  <= col_pos_q;
                    end else begin
                      end_q <= row_pos_q;
                      lo_q  <= dec ? new_axis : col_pos_q;
                      hi_q  <= dec ? col_pos_q : new_axis;
                    end
                  end
                end
              end
              ModeReadCell: begin
                if (q_in_grid) begin
                  cur_q   <= qrow_ext[PW-1:0];
                  qcol_q  <= qcol_ext[PW-1:0];
                  state_q <= StQryRd;
                end
              end
              default: ;
            endcase
          end
        end
        StMarkRd: state_q <= StMarkWr;
        StMarkWr: begin
          if (mark_last) begin
            state_q <= StDone;
          end else begin
            cur_q <= cur_next;
          end
        end
        StQryRd: state_q <= StQryCap;
        StQryCap: begin
          cell_q  <= rd_data[qcol_q];
          state_q <= StDone;
        end
        StDone: begin
          // hold the result until the output register frees
          if (out_free) begin
            out_cell_q  <= cell_q;
            out_row_q   <= row_ext[CoordW-1:0];
            out_col_q   <= col_ext[CoordW-1:0];
            out_head_q  <= heading_q;
            out_pen_q   <= pen_q;
            out_clip_q  <= clip_q;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cell_marked_o = out_cell_q;
  assign row_now_o     = out_row_q;
  assign col_now_o     = out_col_q;
  assign heading_now_o = out_head_q;
  assign pen_is_down_o = out_pen_q;
  assign clipped_o     = out_clip_q;

endmodule
